/* rtl/keyed_credit_table_with_max_macros.svh */
// ----------------------------------------------------------------------------
// Keyed credit table assertion macros
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef KEYED_CREDIT_TABLE_WITH_MAX_MACROS_SVH
`define KEYED_CREDIT_TABLE_WITH_MAX_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define KCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kct check failed");

// next-cycle implication
`define KCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kct check failed");

`else

`define KCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KCT_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/kct_pkg.sv */
// ----------------------------------------------------------------------------
// kct_pkg
// Shared constants, command codes and types of the keyed credit table.
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 16;
  localparam int VAL_W    = 32;
  localparam int CRED_W   = 48;
  localparam int CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ADDALL = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CRED_W-1:0] credit;
  } kct_entry_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    kct_entry_t        data;
  } kct_wr_t;

  typedef struct packed {
    logic              sub;
    logic [CRED_W-1:0] a;
    logic [CRED_W-1:0] b;
    logic [CRED_W-1:0] cmp;
  } kct_alu_req_t;

  typedef struct packed {
    logic [CRED_W-1:0] sum;
    logic              gt;
  } kct_alu_rsp_t;

endpackage

/* rtl/kct_mem.sv */
// ----------------------------------------------------------------------------
// kct_mem
// Entry store: key and relative credit per slot, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module kct_mem
  import kct_pkg::*;
(
  input  logic             clk,
  input  kct_wr_t          wr,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output kct_entry_t       rd_data
);

  kct_entry_t mem_r [CAPACITY];
  kct_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/kct_alu.sv */
// ----------------------------------------------------------------------------
// kct_alu
// Shared 48-bit add/subtract with a signed greater-than against a reference.
// ----------------------------------------------------------------------------
module kct_alu
  import kct_pkg::*;
(
  input  kct_alu_req_t req,
  output kct_alu_rsp_t rsp
);

  logic [CRED_W-1:0] b_op;
  logic [CRED_W-1:0] sum;

  assign b_op    = req.sub ? ~req.b : req.b;
  assign sum     = req.a + b_op + {{(CRED_W-1){1'b0}}, req.sub};
  assign rsp.sum = sum;
  assign rsp.gt  = $signed(sum) > $signed(req.cmp);

endmodule

/* rtl/keyed_credit_table_with_max.sv */
// ----------------------------------------------------------------------------
// keyed_credit_table_with_max
// Client credit table with a global offset and a running maximum report.
//
// Input beat: in_tuser carries the command (insert, remove, lookup, add to
// all), in_tdata the client key and a signed 32-bit credit or amount.
// Output beat: one per input beat, with found/table_full/max_valid in
// out_tuser and the lookup credit plus the top client key in out_tdata.
// Each beat is handled in order: one pass over the entry store finds the key
// and the lowest free slot, an update step applies the command, a second pass
// through the single read port and the shared 48-bit adder/comparator finds
// the maximum, and a final step loads the output.
// in_tready is high only while the sequencer is idle. The result sits in an
// output register, so the next beat is accepted while it waits; a stalled
// receiver holds the block only when the following result is ready.
// Reset empties the table and clears the offset; entry contents are not
// cleared, since the data of an empty slot is never used.
// ----------------------------------------------------------------------------
`include "keyed_credit_table_with_max_macros.svh"

module keyed_credit_table_with_max
  import kct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // client_key[15:0], credit_value[47:16]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // credit_out[47:0], max_client[63:48]
  output logic [2:0]  out_tuser   // found[0], table_full[1], max_valid[2]
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_MAX  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  d_idx_r, d_idx_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_slot_r, hit_slot_nxt;
  logic [CRED_W-1:0] hit_cred_r, hit_cred_nxt;
  logic              free_r, free_nxt;
  logic [IDX_W-1:0]  free_slot_r, free_slot_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CRED_W-1:0] offset_r, offset_nxt;
  logic              found_r, found_nxt;
  logic              full_r, full_nxt;
  logic [CRED_W-1:0] credit_r, credit_nxt;
  logic              mvalid_r, mvalid_nxt;
  logic [CRED_W-1:0] best_r, best_nxt;
  logic [KEY_W-1:0]  mclient_r, mclient_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [63:0]       out_tdata_r, out_tdata_nxt;
  logic [2:0]        out_tuser_r, out_tuser_nxt;

  logic              scanning;
  logic              rd_en;
  logic              data_act;
  kct_entry_t        rd_data;
  kct_wr_t           wr;
  kct_alu_req_t      alu_req;
  kct_alu_rsp_t      alu_rsp;
  logic [CRED_W-1:0] val_ext;
  logic [IDX_W-1:0]  ins_slot;
  logic              ins_ok;

  assign scanning = (state_r == S_FIND) || (state_r == S_MAX);
  assign rd_en    = scanning && (idx_r < CNT_W'(CAPACITY));
  assign data_act = scanning && (idx_r != '0);
  assign val_ext  = {{(CRED_W-VAL_W){val_r[VAL_W-1]}}, val_r};
  assign ins_slot = hit_r ? hit_slot_r : free_slot_r;
  assign ins_ok   = hit_r || free_r;

  kct_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  kct_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // shared adder operand select
  always_comb begin
    alu_req.sub = 1'b0;
    alu_req.a   = rd_data.credit;
    alu_req.b   = offset_r;
    alu_req.cmp = best_r;
    if (state_r == S_UPD) begin
      unique case (cmd_r)
        CMD_INSERT: begin
          alu_req.sub = 1'b1;
          alu_req.a   = val_ext;
        end
        CMD_LOOKUP: begin
          alu_req.a = hit_cred_r;
        end
        CMD_ADDALL: begin
          alu_req.a = offset_r;
          alu_req.b = val_ext;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    d_idx_nxt      = d_idx_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    hit_cred_nxt   = hit_cred_r;
    free_nxt       = free_r;
    free_slot_nxt  = free_slot_r;
    valid_nxt      = valid_r;
    offset_nxt     = offset_r;
    found_nxt      = found_r;
    full_nxt       = full_r;
    credit_nxt     = credit_r;
    mvalid_nxt     = mvalid_r;
    best_nxt       = best_r;
    mclient_nxt    = mclient_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    wr             = '0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    // advance the scan index; data for d_idx_r is on the read port
    if (scanning) begin
      if (rd_en) begin
        idx_nxt   = idx_r + CNT_W'(1);
        d_idx_nxt = idx_r[IDX_W-1:0];
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          key_nxt   = in_tdata[15:0];
          val_nxt   = in_tdata[47:16];
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        if (data_act) begin
          if (valid_r[d_idx_r] && (rd_data.key == key_r) && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_slot_nxt = d_idx_r;
            hit_cred_nxt = rd_data.credit;
          end
          if (!valid_r[d_idx_r] && !free_r) begin
            free_nxt      = 1'b1;
            free_slot_nxt = d_idx_r;
          end
        end
        if (idx_r == CNT_W'(CAPACITY)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        found_nxt  = 1'b0;
        full_nxt   = 1'b0;
        credit_nxt = '0;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (ins_ok) begin
              wr.en              = 1'b1;
              wr.addr            = ins_slot;
              wr.data.key        = key_r;
              wr.data.credit     = alu_rsp.sum;
              valid_nxt[ins_slot] = 1'b1;
            end else begin
              full_nxt = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (hit_r) begin
              valid_nxt[hit_slot_r] = 1'b0;
              found_nxt             = 1'b1;
            end
          end
          CMD_LOOKUP: begin
            found_nxt  = hit_r;
            credit_nxt = hit_r ? alu_rsp.sum : '1;
          end
          CMD_ADDALL: begin
            offset_nxt = alu_rsp.sum;
          end
          default: begin
          end
        endcase
        idx_nxt     = '0;
        mvalid_nxt  = 1'b0;
        best_nxt    = '0;
        mclient_nxt = '0;
        state_nxt   = S_MAX;
      end
      S_MAX: begin
        // strict greater keeps the lowest slot on a tie
        if (data_act && valid_r[d_idx_r] && (!mvalid_r || alu_rsp.gt)) begin
          mvalid_nxt  = 1'b1;
          best_nxt    = alu_rsp.sum;
          mclient_nxt = rd_data.key;
        end
        if (idx_r == CNT_W'(CAPACITY)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {mclient_r, credit_r};
          out_tuser_nxt  = {mvalid_r, full_r, found_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      offset_r     <= '0;
      out_tvalid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      offset_r     <= offset_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    d_idx_r     <= d_idx_nxt;
    hit_r       <= hit_nxt;
    hit_slot_r  <= hit_slot_nxt;
    hit_cred_r  <= hit_cred_nxt;
    free_r      <= free_nxt;
    free_slot_r <= free_slot_nxt;
    found_r     <= found_nxt;
    full_r      <= full_nxt;
    credit_r    <= credit_nxt;
    mvalid_r    <= mvalid_nxt;
    best_r      <= best_nxt;
    mclient_r   <= mclient_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `KCT_ASSERT_NXT(a_accept_starts_scan, clk, rst_n, in_tvalid && in_tready,
                  (state_r == S_FIND) && (idx_r == '0))
  `KCT_ASSERT_IMP(a_idx_in_range, clk, rst_n, scanning, idx_r <= CNT_W'(CAPACITY))
  `KCT_ASSERT_IMP(a_max_matches_occupancy, clk, rst_n, state_r == S_OUT,
                  mvalid_r == (|valid_r))
  `KCT_ASSERT_IMP(a_found_full_exclusive, clk, rst_n, out_tvalid,
                  !(out_tuser[0] && out_tuser[1]))

endmodule
